// File: hw/rtl/nst_pkg.sv
// Shared command and status codes for the named semaphore table.
// No dependencies.
package nst_pkg;
  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_FREE   = 3'd1;
  localparam logic [2:0] CMD_WAIT   = 3'd2;
  localparam logic [2:0] CMD_SIGNAL = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BADID   = 3'd3;
  localparam logic [2:0] ST_WAITERS = 3'd4;
  localparam logic [2:0] ST_BLOCKED = 3'd5;
endpackage

// File: hw/rtl/nst_cell.sv
// One semaphore slot: used flag, name, count and wait queue head/tail.
// Takes part in a lowest-free and duplicate-name scan chain.
module nst_cell #(
  parameter int COUNT_BITS = 16,
  parameter int NAME_BITS  = 48,
  parameter int PID_BITS   = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  free_seen_i,
  input  logic                  dup_seen_i,
  input  logic [NAME_BITS-1:0]  key_i,
  output logic                  free_seen_o,
  output logic                  dup_seen_o,
  output logic                  is_first_free_o,
  input  logic                  alloc_i,
  input  logic [COUNT_BITS-1:0] init_i,
  input  logic                  release_i,
  input  logic                  count_we_i,
  input  logic [COUNT_BITS-1:0] count_d_i,
  input  logic                  head_we_i,
  input  logic                  head_empty_d_i,
  input  logic [PID_BITS-1:0]   head_d_i,
  input  logic                  tail_we_i,
  input  logic [PID_BITS-1:0]   tail_d_i,
  output logic                  used_o,
  output logic [NAME_BITS-1:0]  name_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  head_empty_o,
  output logic [PID_BITS-1:0]   head_o,
  output logic [PID_BITS-1:0]   tail_o
);
  logic                  used_q, empty_q;
  logic [NAME_BITS-1:0]  name_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [PID_BITS-1:0]   head_q, tail_q;

  assign is_first_free_o = !used_q && !free_seen_i;
  assign free_seen_o     = free_seen_i || !used_q;
  assign dup_seen_o      = dup_seen_i || (used_q && name_q == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      empty_q <= 1'b1;
    end else begin
      if (alloc_i) begin
        used_q  <= 1'b1;
        empty_q <= 1'b1;
      end else begin
        if (release_i) used_q <= 1'b0;
        if (head_we_i) empty_q <= head_empty_d_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      name_q  <= key_i;
      count_q <= init_i;
    end else if (count_we_i) begin
      count_q <= count_d_i;
    end
    if (head_we_i) head_q <= head_d_i;
    if (tail_we_i) tail_q <= tail_d_i;
  end

  assign used_o       = used_q;
  assign name_o       = name_q;
  assign count_o      = count_q;
  assign head_empty_o = empty_q;
  assign head_o       = head_q;
  assign tail_o       = tail_q;
endmodule

// File: hw/rtl/named_semaphore_table.sv
// Named semaphore table: a chain of slot cells plus a shared waiter-link memory.
// One item at a time: an accepted item passes through execute, link read and output, which holds
// while out_stall_i is high; the next item is taken only in the idle state that follows.
// Reset (async, active low) clears all slots and queues; no clearing pass.
module named_semaphore_table #(
  parameter int NUM_SEMS   = 16,
  parameter int MAX_PROCS  = 64,
  parameter int COUNT_BITS = 16,
  parameter int NAME_BITS  = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  sem_id_i,
  input  logic [15:0] init_value_i,
  input  logic [47:0] name_key_i,
  input  logic [5:0]  caller_pid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  new_sem_id_o,
  output logic        woken_valid_o,
  output logic [5:0]  woken_pid_o,
  output logic [47:0] name_out_o
);
  localparam int PB = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int SB = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] cmd_q;
  logic [3:0] sid_q;
  logic [COUNT_BITS-1:0] init_q;
  logic [NAME_BITS-1:0] key_q;
  logic [5:0] pid_q;

  logic [2:0]  st_q;
  logic [3:0]  nid_q;
  logic        wv_q;
  logic [5:0]  wpid_q;
  logic [47:0] nout_q;

  logic [MAX_PROCS-1:0] queued_q;
  logic [PB:0] link_mem [MAX_PROCS];
  logic [PB:0] link_rd_q;

  logic [NUM_SEMS:0] free_ch, dup_ch;
  logic [NUM_SEMS-1:0] first_free, used;
  logic [NAME_BITS-1:0]  name_a  [NUM_SEMS];
  logic [COUNT_BITS-1:0] count_a [NUM_SEMS];
  logic [NUM_SEMS-1:0] empty_a;
  logic [PB-1:0] head_a [NUM_SEMS];
  logic [PB-1:0] tail_a [NUM_SEMS];

  logic [NUM_SEMS-1:0] alloc, rel, cnt_we, hd_we, tl_we;
  logic [COUNT_BITS-1:0] cnt_d;
  logic hd_empty_d;
  logic [PB-1:0] hd_d;

  logic sid_ok, valid;
  logic [SB-1:0] sidx;
  logic [NAME_BITS-1:0]  s_name;
  logic [COUNT_BITS-1:0] s_count;
  logic s_empty;
  logic [PB-1:0] s_head, s_tail;
  logic pid_ok;
  logic [PB-1:0] pidx;

  assign free_ch[0] = 1'b0;
  assign dup_ch[0]  = 1'b0;

  for (genvar g = 0; g < NUM_SEMS; g++) begin : g_cell
    nst_cell #(.COUNT_BITS(COUNT_BITS), .NAME_BITS(NAME_BITS), .PID_BITS(PB)) u_cell (
      .clk_i, .rst_ni,
      .free_seen_i(free_ch[g]), .dup_seen_i(dup_ch[g]), .key_i(key_q),
      .free_seen_o(free_ch[g+1]), .dup_seen_o(dup_ch[g+1]),
      .is_first_free_o(first_free[g]),
      .alloc_i(alloc[g]), .init_i(init_q), .release_i(rel[g]),
      .count_we_i(cnt_we[g]), .count_d_i(cnt_d),
      .head_we_i(hd_we[g]), .head_empty_d_i(hd_empty_d), .head_d_i(hd_d),
      .tail_we_i(tl_we[g]), .tail_d_i(pidx),
      .used_o(used[g]), .name_o(name_a[g]), .count_o(count_a[g]),
      .head_empty_o(empty_a[g]), .head_o(head_a[g]), .tail_o(tail_a[g])
    );
  end

  assign sid_ok  = 32'(sid_q) < NUM_SEMS;
  assign sidx    = SB'(sid_q);
  assign valid   = sid_ok && used[sidx];
  assign s_name  = name_a[sidx];
  assign s_count = count_a[sidx];
  assign s_empty = empty_a[sidx];
  assign s_head  = head_a[sidx];
  assign s_tail  = tail_a[sidx];
  assign pid_ok  = 32'(pid_q) < MAX_PROCS;
  assign pidx    = PB'(pid_q);

  logic [SB-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = 0; i < NUM_SEMS; i++) if (first_free[i]) free_idx = SB'(i);
  end

  logic do_exec, do_link;
  assign do_exec = state_q == S_EXEC;
  assign do_link = state_q == S_LINK;

  logic is_wait_blk, is_sig_wake;
  assign is_wait_blk = cmd_q == nst_pkg::CMD_WAIT && valid && s_count == '0 && pid_ok
                       && !queued_q[pidx];
  assign is_sig_wake = cmd_q == nst_pkg::CMD_SIGNAL && valid && !s_empty;

  always_comb begin
    alloc = '0; rel = '0; cnt_we = '0; hd_we = '0; tl_we = '0;
    cnt_d = s_count; hd_empty_d = 1'b0; hd_d = pidx;
    if (do_exec) begin
      case (cmd_q)
        nst_pkg::CMD_CREATE: begin
          if (!dup_ch[NUM_SEMS] && free_ch[NUM_SEMS]) alloc[free_idx] = 1'b1;
        end
        nst_pkg::CMD_FREE: begin
          if (valid && s_empty) rel[sidx] = 1'b1;
        end
        nst_pkg::CMD_WAIT: begin
          if (valid && s_count != '0) begin
            cnt_we[sidx] = 1'b1;
            cnt_d = s_count - 1'b1;
          end else if (is_wait_blk) begin
            tl_we[sidx] = 1'b1;
            if (s_empty) hd_we[sidx] = 1'b1;
          end
        end
        nst_pkg::CMD_SIGNAL: begin
          if (valid && s_count != CMAX) begin
            cnt_we[sidx] = 1'b1;
            cnt_d = s_count + 1'b1;
          end
        end
        default: ;
      endcase
    end else if (do_link && is_sig_wake) begin
      hd_we[sidx] = 1'b1;
      hd_empty_d  = link_rd_q[PB];
      hd_d        = link_rd_q[PB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_exec) begin
      if (is_wait_blk) begin
        link_mem[pidx] <= {1'b1, {PB{1'b0}}};
        if (!s_empty) link_mem[s_tail] <= {1'b0, pidx};
      end
      link_rd_q <= link_mem[s_head];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q <= '0;
    end else if (do_exec) begin
      if (is_wait_blk) queued_q[pidx] <= 1'b1;
      if (is_sig_wake) queued_q[s_head] <= 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: state_d = S_LINK;
      S_LINK: state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q  <= cmd_i;
      sid_q  <= sem_id_i;
      init_q <= COUNT_BITS'(init_value_i);
      key_q  <= NAME_BITS'(name_key_i);
      pid_q  <= caller_pid_i;
    end
    if (do_exec) begin
      st_q <= nst_pkg::ST_OK; nid_q <= '0; wv_q <= 1'b0; wpid_q <= '0; nout_q <= '0;
      if (cmd_q == nst_pkg::CMD_CREATE) begin
        if (dup_ch[NUM_SEMS]) st_q <= nst_pkg::ST_DUP;
        else if (!free_ch[NUM_SEMS]) st_q <= nst_pkg::ST_FULL;
        else nid_q <= 4'(free_idx);
      end else if (cmd_q > nst_pkg::CMD_QUERY || !valid) begin
        st_q <= nst_pkg::ST_BADID;
      end else begin
        case (cmd_q)
          nst_pkg::CMD_FREE: if (!s_empty) st_q <= nst_pkg::ST_WAITERS;
          nst_pkg::CMD_WAIT: begin
            if (s_count == '0) st_q <= pid_ok ? nst_pkg::ST_BLOCKED : nst_pkg::ST_BADID;
          end
          nst_pkg::CMD_SIGNAL: begin
            if (!s_empty) begin
              wv_q   <= 1'b1;
              wpid_q <= 6'(s_head);
            end
          end
          default: nout_q <= 48'(s_name);
        endcase
      end
    end
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = state_q == S_OUT;
  assign status_o      = st_q;
  assign new_sem_id_o  = nid_q;
  assign woken_valid_o = wv_q;
  assign woken_pid_o   = wpid_q;
  assign name_out_o    = nout_q;
endmodule

// File: hw/rtl/nst_checker.sv
// Port-level checks for named_semaphore_table, bound to the top level.
// Depends on nst_pkg.
module nst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [3:0]  new_sem_id_o,
  input logic        woken_valid_o,
  input logic [5:0]  woken_pid_o,
  input logic [47:0] name_out_o
);
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ##2 out_valid_o) else $error("result late");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");
  a_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && woken_valid_o) |-> status_o == nst_pkg::ST_OK)
    else $error("wake with error status");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != nst_pkg::ST_OK) |->
      (new_sem_id_o == 4'd0 && !woken_valid_o && woken_pid_o == 6'd0
       && name_out_o == 48'd0)) else $error("fields set on error");
endmodule

bind named_semaphore_table nst_checker u_nst_checker (.*);
